// ----- hw/rtl/asmu_pkg.sv -----
package asmu_pkg;

    // Control of one fused multiply-add: negate the product and/or the addend.
    typedef struct packed {
        logic neg_prod;
        logic neg_addend;
    } fma_op_t;

    localparam fma_op_t FMA_PLAIN   = '{neg_prod: 1'b0, neg_addend: 1'b0};
    localparam fma_op_t FMA_NEG_PRD = '{neg_prod: 1'b1, neg_addend: 1'b0};
    localparam fma_op_t FMA_NEG_ADD = '{neg_prod: 1'b0, neg_addend: 1'b1};

    // Cycles from operands at the unit's inputs to the registered result.
    localparam int FMA_LATENCY = 5;

    // Configuration register indexes.
    localparam logic [1:0] REG_STORAGE_FORMAT  = 2'd0;
    localparam logic [1:0] REG_GRADIENT_SCALE  = 2'd1;
    localparam logic [1:0] REG_STEP_SIZE       = 2'd2;
    localparam logic [1:0] REG_EPSILON_SQUARED = 2'd3;

    // Binary32 constants.
    localparam logic [31:0] FP_ONE          = 32'h3F80_0000;
    localparam logic [31:0] FP_HALF         = 32'h3F00_0000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3FC0_0000;
    localparam logic [31:0] FP_BETA2        = 32'h3F7F_F972;
    localparam logic [31:0] FP_ONE_M_BETA2  = 32'h38D1_C000;
    localparam logic [31:0] FP_NEG_ZERO     = 32'h8000_0000;
    localparam logic [31:0] DEFAULT_NAN     = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT       = 32'h0040_0000;
    localparam logic [31:0] RSQRT_MAGIC     = 32'h5F37_59DF;
    localparam logic [31:0] BF16_BIAS       = 32'h0000_8000;
    localparam logic [31:0] BF16_ROUND      = 32'h0000_7FFF;

endpackage

// ----- hw/rtl/adam_second_moment_update.sv -----
// A result passes through the input register, the fused multiply-add chain and the output register.
// Throughput: one item per cycle; eleven chained five-stage fused multiply-add units
// set the depth, and a stalled output holds the whole pipeline without loss.
// Reset (rst_n low, asynchronous): all valid bits clear, registers take their defaults
// (binary32 storage, gradient scale 1.0, step size 0, epsilon squared 0).
module adam_second_moment_update (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] gradient_word, [63:32] variance_word, [79:64] param_high, [95:80] param_low
    input  logic [95:0] s_tdata,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] new_param_high, [31:16] new_param_low, [63:32] new_variance_word
    output logic [63:0] m_tdata,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int LAT  = asmu_pkg::FMA_LATENCY;
    localparam int LAST = 11 * LAT + 1;

    logic        storage_format_reg;
    logic [31:0] gradient_scale_reg, step_size_reg, epsilon_squared_reg;
    logic [LAST:0] vld_reg, vld_next;
    logic        en;

    logic [31:0] grad_in_reg, var_in_reg, param_in_reg;
    logic [31:0] param_word;
    logic [31:0] g_val, gg_val, gs_val, t_val, nv_val, s_val, half_val, he_val;
    logic [31:0] corr_val, r_val, upd_val, np_val;
    logic [31:0] var_d, gs_d, param_d, nv_d;
    logic [31:0] est_val, est_a, est_b, est_c;
    logic [31:0] np_out_reg, vout_reg;
    logic [31:0] np_biased, nv_rounded;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            storage_format_reg  <= 1'b0;
            gradient_scale_reg  <= asmu_pkg::FP_ONE;
            step_size_reg       <= 32'd0;
            epsilon_squared_reg <= 32'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                asmu_pkg::REG_STORAGE_FORMAT:  storage_format_reg  <= cfg_data[0];
                asmu_pkg::REG_GRADIENT_SCALE:  gradient_scale_reg  <= cfg_data;
                asmu_pkg::REG_STEP_SIZE:       step_size_reg       <= cfg_data;
                asmu_pkg::REG_EPSILON_SQUARED: epsilon_squared_reg <= cfg_data;
                default:                       storage_format_reg  <= storage_format_reg;
            endcase
        end
    end

    // The pipeline advances unless a finished result is waiting.
    assign en       = !vld_reg[LAST] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAST];
    assign vld_next = {vld_reg[LAST-1:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Input register; bf16 mode widens the halves and removes the parameter bias.
    assign param_word = {s_tdata[79:64], s_tdata[95:80]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (storage_format_reg)
            begin
                grad_in_reg  <= {s_tdata[15:0], 16'd0};
                var_in_reg   <= {s_tdata[47:32], 16'd0};
                param_in_reg <= param_word - asmu_pkg::BF16_BIAS;
            end
            else
            begin
                grad_in_reg  <= s_tdata[31:0];
                var_in_reg   <= s_tdata[63:32];
                param_in_reg <= param_word;
            end
        end
    end

    // Scaled gradient.
    asmu_fma u_scale (.clk(clk), .en(en), .a(grad_in_reg), .b(gradient_scale_reg),
                      .c(asmu_pkg::FP_NEG_ZERO), .op(asmu_pkg::FMA_PLAIN), .res(g_val));

    // Gradient squared, and gradient times step size.
    asmu_fma u_sq (.clk(clk), .en(en), .a(g_val), .b(g_val),
                   .c(asmu_pkg::FP_NEG_ZERO), .op(asmu_pkg::FMA_PLAIN), .res(gg_val));
    asmu_fma u_gs (.clk(clk), .en(en), .a(g_val), .b(step_size_reg),
                   .c(asmu_pkg::FP_NEG_ZERO), .op(asmu_pkg::FMA_PLAIN), .res(gs_val));

    // Squared gradient times (1 - beta2).
    asmu_fma u_t (.clk(clk), .en(en), .a(gg_val), .b(asmu_pkg::FP_ONE_M_BETA2),
                  .c(asmu_pkg::FP_NEG_ZERO), .op(asmu_pkg::FMA_PLAIN), .res(t_val));

    // New second moment: v * beta2 + t.
    asmu_delay #(.WIDTH(32), .DEPTH(3 * LAT)) u_var_d (.clk(clk), .en(en),
                                                      .d(var_in_reg), .q(var_d));
    asmu_fma u_nv (.clk(clk), .en(en), .a(var_d), .b(asmu_pkg::FP_BETA2),
                   .c(t_val), .op(asmu_pkg::FMA_PLAIN), .res(nv_val));

    // Add epsilon squared.
    asmu_fma u_eps (.clk(clk), .en(en), .a(nv_val), .b(asmu_pkg::FP_ONE),
                    .c(epsilon_squared_reg), .op(asmu_pkg::FMA_PLAIN), .res(s_val));

    // Reciprocal square root: bit estimate and one Newton step.
    assign est_val = asmu_pkg::RSQRT_MAGIC - {1'b0, s_val[31:1]};

    asmu_fma u_half (.clk(clk), .en(en), .a(s_val), .b(asmu_pkg::FP_HALF),
                     .c(asmu_pkg::FP_NEG_ZERO), .op(asmu_pkg::FMA_PLAIN), .res(half_val));
    asmu_delay #(.WIDTH(32), .DEPTH(LAT)) u_est_a (.clk(clk), .en(en),
                                                  .d(est_val), .q(est_a));
    asmu_fma u_he (.clk(clk), .en(en), .a(half_val), .b(est_a),
                   .c(asmu_pkg::FP_NEG_ZERO), .op(asmu_pkg::FMA_PLAIN), .res(he_val));
    asmu_delay #(.WIDTH(32), .DEPTH(LAT)) u_est_b (.clk(clk), .en(en),
                                                  .d(est_a), .q(est_b));
    asmu_fma u_corr (.clk(clk), .en(en), .a(est_b), .b(he_val),
                     .c(asmu_pkg::FP_THREE_HALVES), .op(asmu_pkg::FMA_NEG_PRD),
                     .res(corr_val));
    asmu_delay #(.WIDTH(32), .DEPTH(LAT)) u_est_c (.clk(clk), .en(en),
                                                  .d(est_b), .q(est_c));
    asmu_fma u_r (.clk(clk), .en(en), .a(corr_val), .b(est_c),
                  .c(asmu_pkg::FP_NEG_ZERO), .op(asmu_pkg::FMA_PLAIN), .res(r_val));

    // Update term and new parameter.
    asmu_delay #(.WIDTH(32), .DEPTH(7 * LAT)) u_gs_d (.clk(clk), .en(en),
                                                     .d(gs_val), .q(gs_d));
    asmu_fma u_upd (.clk(clk), .en(en), .a(r_val), .b(gs_d),
                    .c(asmu_pkg::FP_NEG_ZERO), .op(asmu_pkg::FMA_PLAIN), .res(upd_val));
    asmu_delay #(.WIDTH(32), .DEPTH(10 * LAT)) u_param_d (.clk(clk), .en(en),
                                                         .d(param_in_reg), .q(param_d));
    asmu_fma u_np (.clk(clk), .en(en), .a(param_d), .b(asmu_pkg::FP_ONE),
                   .c(upd_val), .op(asmu_pkg::FMA_NEG_ADD), .res(np_val));

    // Second moment travels alongside to the output.
    asmu_delay #(.WIDTH(32), .DEPTH(7 * LAT)) u_nv_d (.clk(clk), .en(en),
                                                     .d(nv_val), .q(nv_d));

    // Output register with bf16 packing.
    assign np_biased  = np_val + asmu_pkg::BF16_BIAS;
    assign nv_rounded = nv_d + asmu_pkg::BF16_ROUND + {31'd0, nv_d[16]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (storage_format_reg)
            begin
                np_out_reg <= np_biased;
                vout_reg   <= {16'd0, nv_rounded[31:16]};
            end
            else
            begin
                np_out_reg <= np_val;
                vout_reg   <= nv_d;
            end
        end
    end

    assign m_tdata = {vout_reg, np_out_reg[15:0], np_out_reg[31:16]};

endmodule

// ----- hw/rtl/asmu_delay.sv -----
module asmu_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 5
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    // Shift line that moves only when the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

// ----- hw/rtl/asmu_fma.sv -----
module asmu_fma (
    input  logic              clk,
    input  logic              en,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    input  logic [31:0]       c,
    input  asmu_pkg::fma_op_t op,
    output logic [31:0]       res
);

    // ---------------- Stage 1: unpack, specials, significand product ----------------
    logic [7:0]         a_exp, b_exp, c_exp;
    logic [7:0]         a_eff, b_eff, c_eff;
    logic [23:0]        a_man, b_man, c_man;
    logic               a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
    logic               p_sign, c_sign;
    logic signed [10:0] a_e, b_e, c_e;
    logic               spec_next;
    logic [31:0]        spec_val_next;

    logic [47:0]        s1_prod_reg;
    logic [23:0]        s1_cman_reg;
    logic signed [10:0] s1_diff_reg, s1_kp_reg, s1_kc_reg;
    logic               s1_psign_reg, s1_csign_reg, s1_pzero_reg, s1_czero_reg;
    logic               s1_spec_reg;
    logic [31:0]        s1_spec_val_reg;

    assign a_exp  = a[30:23];
    assign b_exp  = b[30:23];
    assign c_exp  = c[30:23];
    assign a_eff  = (a_exp == 8'd0) ? 8'd1 : a_exp;
    assign b_eff  = (b_exp == 8'd0) ? 8'd1 : b_exp;
    assign c_eff  = (c_exp == 8'd0) ? 8'd1 : c_exp;
    assign a_man  = {a_exp != 8'd0, a[22:0]};
    assign b_man  = {b_exp != 8'd0, b[22:0]};
    assign c_man  = {c_exp != 8'd0, c[22:0]};
    assign a_nan  = (a_exp == 8'hFF) && (a[22:0] != 23'd0);
    assign b_nan  = (b_exp == 8'hFF) && (b[22:0] != 23'd0);
    assign c_nan  = (c_exp == 8'hFF) && (c[22:0] != 23'd0);
    assign a_inf  = (a_exp == 8'hFF) && (a[22:0] == 23'd0);
    assign b_inf  = (b_exp == 8'hFF) && (b[22:0] == 23'd0);
    assign c_inf  = (c_exp == 8'hFF) && (c[22:0] == 23'd0);
    assign a_zero = (a[30:0] == 31'd0);
    assign b_zero = (b[30:0] == 31'd0);
    assign c_zero = (c[30:0] == 31'd0);
    assign p_sign = a[31] ^ b[31] ^ op.neg_prod;
    assign c_sign = c[31] ^ op.neg_addend;
    assign a_e    = $signed({3'b000, a_eff});
    assign b_e    = $signed({3'b000, b_eff});
    assign c_e    = $signed({3'b000, c_eff});

    // NaN operands win in operand order, then invalid cases, then infinities.
    always_comb
    begin
        spec_next     = 1'b1;
        spec_val_next = 32'd0;
        if (a_nan)
        begin
            spec_val_next = a | asmu_pkg::QUIET_BIT;
        end
        else if (b_nan)
        begin
            spec_val_next = b | asmu_pkg::QUIET_BIT;
        end
        else if (c_nan)
        begin
            spec_val_next = c | asmu_pkg::QUIET_BIT;
        end
        else if ((a_inf && b_zero) || (b_inf && a_zero))
        begin
            spec_val_next = asmu_pkg::DEFAULT_NAN;
        end
        else if ((a_inf || b_inf) && c_inf && (p_sign != c_sign))
        begin
            spec_val_next = asmu_pkg::DEFAULT_NAN;
        end
        else if (a_inf || b_inf)
        begin
            spec_val_next = {p_sign, 8'hFF, 23'd0};
        end
        else if (c_inf)
        begin
            spec_val_next = {c_sign, 8'hFF, 23'd0};
        end
        else
        begin
            spec_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg     <= a_man * b_man;
            s1_cman_reg     <= c_man;
            s1_diff_reg     <= a_e + b_e - c_e - 11'sd126;
            s1_kp_reg       <= a_e + b_e - 11'sd329;
            s1_kc_reg       <= c_e - 11'sd203;
            s1_psign_reg    <= p_sign;
            s1_csign_reg    <= c_sign;
            s1_pzero_reg    <= a_zero || b_zero;
            s1_czero_reg    <= c_zero;
            s1_spec_reg     <= spec_next;
            s1_spec_val_reg <= spec_val_next;
        end
    end

    // ---------------- Stage 2: align the smaller operand and add ----------------
    logic               big_is_prod;
    logic [75:0]        big_val, small_val;
    logic signed [10:0] shift_dist;
    logic [6:0]         align_amt;
    logic [151:0]       align_wide;
    logic               big_sign, small_sign;
    logic [78:0]        big_x, small_x, diff_x, sum_x;
    logic               sum_sign;

    logic [77:0]        s2_sum_reg;
    logic               s2_sign_reg, s2_zsign_reg, s2_spec_reg;
    logic signed [10:0] s2_k_reg;
    logic [31:0]        s2_spec_val_reg;

    always_comb
    begin
        big_is_prod = s1_czero_reg || (!s1_pzero_reg && !s1_diff_reg[10]);
        big_val     = big_is_prod ? {s1_prod_reg, 28'd0} : {s1_cman_reg, 52'd0};
        small_val   = big_is_prod ? {s1_cman_reg, 52'd0} : {s1_prod_reg, 28'd0};
        big_sign    = big_is_prod ? s1_psign_reg : s1_csign_reg;
        small_sign  = big_is_prod ? s1_csign_reg : s1_psign_reg;
        shift_dist  = big_is_prod ? s1_diff_reg : -s1_diff_reg;
        if (shift_dist[10])
        begin
            align_amt = 7'd0;
        end
        else if (shift_dist > 11'sd76)
        begin
            align_amt = 7'd76;
        end
        else
        begin
            align_amt = shift_dist[6:0];
        end
        align_wide = {small_val, 76'd0} >> align_amt;
        big_x      = {2'b00, big_val, 1'b0};
        small_x    = {2'b00, align_wide[151:76], |align_wide[75:0]};
        diff_x     = big_x - small_x;
        if (big_sign == small_sign)
        begin
            sum_x    = big_x + small_x;
            sum_sign = big_sign;
        end
        else if (diff_x[78])
        begin
            sum_x    = small_x - big_x;
            sum_sign = small_sign;
        end
        else
        begin
            sum_x    = diff_x;
            sum_sign = big_sign;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_sum_reg      <= sum_x[77:0];
            s2_sign_reg     <= sum_sign;
            s2_zsign_reg    <= s1_psign_reg & s1_csign_reg;
            s2_k_reg        <= big_is_prod ? s1_kp_reg : s1_kc_reg;
            s2_spec_reg     <= s1_spec_reg;
            s2_spec_val_reg <= s1_spec_val_reg;
        end
    end

    // ---------------- Stage 3: leading zero count ----------------
    logic [6:0]         lz_count;

    logic [77:0]        s3_sum_reg;
    logic [6:0]         s3_lz_reg;
    logic signed [10:0] s3_k_reg, s3_limit_reg;
    logic               s3_sign_reg, s3_zsign_reg, s3_zero_reg, s3_spec_reg;
    logic [31:0]        s3_spec_val_reg;

    always_comb
    begin
        lz_count = 7'd78;
        for (int i = 0; i < 78; i++)
        begin
            if (s2_sum_reg[i])
            begin
                lz_count = 7'(77 - i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_sum_reg      <= s2_sum_reg;
            s3_lz_reg       <= lz_count;
            s3_k_reg        <= s2_k_reg;
            s3_limit_reg    <= s2_k_reg + 11'sd203;
            s3_sign_reg     <= s2_sign_reg;
            s3_zsign_reg    <= s2_zsign_reg;
            s3_zero_reg     <= (s2_sum_reg == 78'd0);
            s3_spec_reg     <= s2_spec_reg;
            s3_spec_val_reg <= s2_spec_val_reg;
        end
    end

    // ---------------- Stage 4: normalize, clamped at the subnormal range ----------------
    logic signed [10:0] neg_limit;
    logic [6:0]         rsh_amt, lsh_amt;
    logic [155:0]       rsh_wide;
    logic [77:0]        norm_val;
    logic signed [10:0] norm_exp;

    logic [77:0]        s4_norm_reg;
    logic signed [10:0] s4_exp_reg;
    logic               s4_sign_reg, s4_zsign_reg, s4_zero_reg, s4_spec_reg;
    logic [31:0]        s4_spec_val_reg;

    always_comb
    begin
        neg_limit = -s3_limit_reg;
        rsh_amt   = (neg_limit > 11'sd78) ? 7'd78 : neg_limit[6:0];
        lsh_amt   = ($signed({4'b0000, s3_lz_reg}) < s3_limit_reg) ? s3_lz_reg
                                                                   : s3_limit_reg[6:0];
        rsh_wide  = {s3_sum_reg, 78'd0} >> rsh_amt;
        if (s3_limit_reg[10])
        begin
            norm_val = {rsh_wide[155:79], rsh_wide[78] | (|rsh_wide[77:0])};
            norm_exp = 11'sd1;
        end
        else
        begin
            norm_val = s3_sum_reg << lsh_amt;
            norm_exp = s3_k_reg + 11'sd204 - $signed({4'b0000, lsh_amt});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_norm_reg     <= norm_val;
            s4_exp_reg      <= norm_exp;
            s4_sign_reg     <= s3_sign_reg;
            s4_zsign_reg    <= s3_zsign_reg;
            s4_zero_reg     <= s3_zero_reg;
            s4_spec_reg     <= s3_spec_reg;
            s4_spec_val_reg <= s3_spec_val_reg;
        end
    end

    // ---------------- Stage 5: round to nearest even and pack ----------------
    logic [30:0] packed_mag, rounded_mag;
    logic        round_up;
    logic [31:0] result_next;
    logic [31:0] s5_res_reg;

    always_comb
    begin
        packed_mag  = s4_norm_reg[77] ? {s4_exp_reg[7:0], s4_norm_reg[76:54]}
                                      : {8'd0, s4_norm_reg[76:54]};
        round_up    = s4_norm_reg[53] & ((|s4_norm_reg[52:0]) | s4_norm_reg[54]);
        rounded_mag = packed_mag + {30'd0, round_up};
        if (s4_spec_reg)
        begin
            result_next = s4_spec_val_reg;
        end
        else if (s4_zero_reg)
        begin
            result_next = {s4_zsign_reg, 31'd0};
        end
        else if (s4_norm_reg[77] && (s4_exp_reg > 11'sd254))
        begin
            result_next = {s4_sign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            result_next = {s4_sign_reg, rounded_mag};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_res_reg <= result_next;
        end
    end

    assign res = s5_res_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // Percent of cycles in which each side holds off.
    int send_idle;
    int recv_idle;

    adam_second_moment_update uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Binary32 helpers: exact integer arithmetic with a single rounding step.
    function automatic bit fp_is_nan(input logic [31:0] x);
        return x[30:0] > 31'h7F80_0000;
    endfunction

    function automatic void fp_unpack(input logic [31:0] x, output logic [23:0] m,
                                      output int e);
        if (x[30:23] == 8'd0)
        begin
            m = {1'b0, x[22:0]};
            e = -149;
        end
        else
        begin
            m = {1'b1, x[22:0]};
            e = int'(x[30:23]) - 150;
        end
    endfunction

    // Round sign * mag * 2^e to nearest even, with subnormals and overflow to infinity.
    function automatic logic [31:0] fp_round(input logic s, input logic [511:0] mag,
                                             input int e);
        int k;
        int q;
        int sh;
        logic [511:0] m;
        logic [511:0] low_mask;
        bit guard;
        bit sticky;
        if (mag == '0)
            return {s, 31'd0};
        k = 511;
        while (!mag[k])
            k--;
        q = k + e - 23;
        if (q < -149)
            q = -149;
        sh = q - e;
        if (sh <= 0)
            m = mag << (-sh);
        else
        begin
            m = mag >> sh;
            guard = mag[sh-1];
            low_mask = (512'd1 << (sh - 1)) - 512'd1;
            sticky = |(mag & low_mask);
            if (guard && (sticky || m[0]))
                m = m + 512'd1;
        end
        if (m[24])
        begin
            m = m >> 1;
            q++;
        end
        if (m[23])
        begin
            if (q + 150 >= 255)
                return {s, 31'h7F80_0000};
            return {s, 8'(q + 150), m[22:0]};
        end
        return {s, 8'd0, m[22:0]};
    endfunction

    // (+/-)a*b (+/- c): the product is exact, one rounding at the end.
    function automatic logic [31:0] fp_fused(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input bit neg_p,
                                             input bit neg_c, input bit has_c);
        logic [23:0] ma;
        logic [23:0] mb;
        logic [23:0] mc;
        logic [47:0] mp;
        logic [511:0] xp;
        logic [511:0] xc;
        logic [511:0] mag;
        int ea;
        int eb;
        int ec;
        int ep;
        int emin;
        logic sp;
        logic sc;
        logic sr;
        bit a_inf;
        bit b_inf;
        bit infp;
        bit infc;
        if (fp_is_nan(a))
            return a | asmu_pkg::QUIET_BIT;
        if (fp_is_nan(b))
            return b | asmu_pkg::QUIET_BIT;
        if (has_c && fp_is_nan(c))
            return c | asmu_pkg::QUIET_BIT;
        a_inf = a[30:0] == 31'h7F80_0000;
        b_inf = b[30:0] == 31'h7F80_0000;
        if ((a_inf && b[30:0] == 31'd0) || (b_inf && a[30:0] == 31'd0))
            return asmu_pkg::DEFAULT_NAN;
        sp = a[31] ^ b[31] ^ neg_p;
        sc = c[31] ^ neg_c;
        infp = a_inf || b_inf;
        infc = has_c && c[30:0] == 31'h7F80_0000;
        if (infp && infc && sp != sc)
            return asmu_pkg::DEFAULT_NAN;
        if (infp)
            return {sp, 31'h7F80_0000};
        if (infc)
            return {sc, 31'h7F80_0000};
        fp_unpack(a, ma, ea);
        fp_unpack(b, mb, eb);
        mp = ma * mb;
        ep = ea + eb;
        if (!has_c)
            return fp_round(sp, {464'd0, mp}, ep);
        fp_unpack(c, mc, ec);
        emin = (ep < ec) ? ep : ec;
        xp = {464'd0, mp} << (ep - emin);
        xc = {488'd0, mc} << (ec - emin);
        if (sp == sc)
        begin
            mag = xp + xc;
            sr = sp;
        end
        else if (xp >= xc)
        begin
            mag = xp - xc;
            sr = sp;
        end
        else
        begin
            mag = xc - xp;
            sr = sc;
        end
        // An exact cancellation gives +0.
        if (mag == '0 && sp != sc)
            sr = 1'b0;
        return fp_round(sr, mag, emin);
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        return fp_fused(a, b, 32'd0, 1'b0, 1'b0, 1'b0);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b,
                                           input bit subtract);
        return fp_fused(a, asmu_pkg::FP_ONE, b, 1'b0, subtract, 1'b1);
    endfunction

    // Bit estimate of 1/sqrt(x) refined by one Newton step.
    function automatic logic [31:0] inv_sqrt(input logic [31:0] x);
        logic [31:0] half;
        logic [31:0] est;
        logic [31:0] corr;
        half = fp_mul(x, asmu_pkg::FP_HALF);
        est = asmu_pkg::RSQRT_MAGIC - (x >> 1);
        corr = fp_fused(est, fp_mul(half, est), asmu_pkg::FP_THREE_HALVES, 1'b1, 1'b0,
                        1'b1);
        return fp_mul(corr, est);
    endfunction

    // Expected updated parameter and second moment for one input transaction.
    function automatic logic [63:0] predict_update(input logic [95:0] item, input bit bf,
                                                   input logic [31:0] scale,
                                                   input logic [31:0] alpha,
                                                   input logic [31:0] eps2);
        logic [31:0] word;
        logic [31:0] g;
        logic [31:0] v;
        logic [31:0] p;
        logic [31:0] nv;
        logic [31:0] upd;
        logic [31:0] np;
        logic [31:0] vout;
        logic [31:0] one_minus;
        word = {item[79:64], item[95:80]};
        if (bf)
        begin
            g = {item[15:0], 16'd0};
            v = {item[47:32], 16'd0};
            p = word - asmu_pkg::BF16_BIAS;
        end
        else
        begin
            g = item[31:0];
            v = item[63:32];
            p = word;
        end
        one_minus = fp_add(asmu_pkg::FP_ONE, asmu_pkg::FP_BETA2, 1'b1);
        g = fp_mul(g, scale);
        nv = fp_fused(v, asmu_pkg::FP_BETA2, fp_mul(fp_mul(g, g), one_minus), 1'b0, 1'b0,
                      1'b1);
        upd = fp_mul(inv_sqrt(fp_add(nv, eps2, 1'b0)), fp_mul(g, alpha));
        np = fp_add(p, upd, 1'b1);
        if (bf)
        begin
            np = np + asmu_pkg::BF16_BIAS;
            vout = ((nv + asmu_pkg::BF16_ROUND + {31'd0, nv[16]}) >> 16) & 32'h0000_FFFF;
        end
        else
            vout = nv;
        return {vout, np[15:0], np[31:16]};
    endfunction

    // Holds the settings seen by the block and the updates still owed by it.
    class update_board;
        bit          bf_mode;
        logic [31:0] scale;
        logic [31:0] alpha;
        logic [31:0] eps2;
        logic [63:0] owed_updates[$];
        int          errors;

        function new();
            bf_mode = 1'b0;
            scale = asmu_pkg::FP_ONE;
            alpha = 32'd0;
            eps2 = 32'd0;
            errors = 0;
        endfunction

        function void write_reg(input logic [1:0] index, input logic [31:0] value);
            case (index)
                asmu_pkg::REG_STORAGE_FORMAT:  bf_mode = value[0];
                asmu_pkg::REG_GRADIENT_SCALE:  scale = value;
                asmu_pkg::REG_STEP_SIZE:       alpha = value;
                asmu_pkg::REG_EPSILON_SQUARED: eps2 = value;
                default:                       ;
            endcase
        endfunction

        function void note_input(input logic [95:0] item);
            owed_updates = {owed_updates,
                            predict_update(item, bf_mode, scale, alpha, eps2)};
        endfunction

        task report(input string what, input logic [31:0] got, input logic [31:0] want);
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
            errors++;
        endtask

        task check_result(input logic [63:0] res);
            logic [63:0] want;
            if (owed_updates.size() == 0)
            begin
                report("unexpected result", res[31:0], 32'd0);
                return;
            end
            want = owed_updates.pop_front();
            if (res[15:0] != want[15:0])
                report("new_param_high", {16'd0, res[15:0]}, {16'd0, want[15:0]});
            if (res[31:16] != want[31:16])
                report("new_param_low", {16'd0, res[31:16]}, {16'd0, want[31:16]});
            if (res[63:32] != want[63:32])
                report("new_variance_word", res[63:32], want[63:32]);
        endtask
    endclass

    update_board board = new();

    // Clock.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Watch all three channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                board.note_input(s_tdata);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
        end
    end

    // Receiver back-pressure.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    // Run limit.
    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [95:0] make_item(input logic [31:0] g, input logic [31:0] v,
                                              input logic [31:0] p);
        return {p[15:0], p[31:16], v, g};
    endfunction

    // Mostly values in a typical training range, sometimes raw bits or special values.
    function automatic logic [31:0] rand_float(input int lo_exp, input int hi_exp,
                                               input bit positive);
        int kind;
        logic [31:0] specials[9];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'h7F80_0001, 32'h0000_0001, 32'h7F7F_FFFF,
                     32'h3F80_0000};
        kind = $urandom_range(19);
        if (kind < 2)
            return $urandom;
        if (kind == 2)
            return specials[$urandom_range(8)];
        return {positive ? 1'b0 : 1'($urandom), 8'($urandom_range(hi_exp, lo_exp)),
                23'($urandom)};
    endfunction

    // One input transaction; the sender may hold off before it.
    task send_item(input logic [95:0] item);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= item;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task send_random(input int count, input bit bf);
        logic [31:0] g;
        logic [31:0] v;
        logic [31:0] p;
        repeat (count)
        begin
            g = rand_float(100, 130, 1'b0);
            v = rand_float(80, 120, 1'b1);
            p = rand_float(110, 130, 1'b0);
            if (bf)
            begin
                g = {16'($urandom), g[31:16]};
                v = {16'($urandom), v[31:16]};
                p = p + asmu_pkg::BF16_BIAS;
            end
            send_item(make_item(g, v, p));
        end
        s_tvalid <= 1'b0;
    endtask

    // Settings change only once the pipeline has emptied.
    task wait_drained();
        while (board.owed_updates.size() != 0)
            @(negedge clk);
        repeat (60)
            @(negedge clk);
    endtask

    task write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task set_all(input logic [31:0] fmt, input logic [31:0] scale, input logic [31:0] alpha,
                 input logic [31:0] eps2);
        wait_drained();
        write_reg(asmu_pkg::REG_STORAGE_FORMAT, fmt);
        write_reg(asmu_pkg::REG_GRADIENT_SCALE, scale);
        write_reg(asmu_pkg::REG_STEP_SIZE, alpha);
        write_reg(asmu_pkg::REG_EPSILON_SQUARED, eps2);
        cfg_valid <= 1'b0;
    endtask

    logic [95:0] plain_cases[20];
    logic [95:0] bf_cases[7];

    initial
    begin
        plain_cases = '{
            make_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000),
            make_item(32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000),
            make_item(32'hBF80_0000, 32'h3F80_0000, 32'hBF80_0000),
            make_item(32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000),
            make_item(32'hFF80_0000, 32'h0000_0000, 32'h3F80_0000),
            make_item(32'h7FC0_0001, 32'h3F80_0000, 32'h3F80_0000),
            make_item(32'h7F80_0001, 32'h7F80_0002, 32'h7F80_0003),
            make_item(32'h3F80_0000, 32'hFF80_0005, 32'h3F80_0000),
            make_item(32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000),
            make_item(32'h3F80_0000, 32'h7F80_0000, 32'h3F80_0000),
            make_item(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF),
            make_item(32'h0000_0001, 32'h007F_FFFF, 32'h0000_0001),
            make_item(32'h3A83_126F, 32'h3400_0000, 32'h7FA0_0000),
            make_item(32'h3A83_126F, 32'h3400_0000, 32'hFF80_0000),
            make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
            make_item(32'h1E3C_E508, 32'h0000_0000, 32'h3DCC_CCCD),
            make_item(32'h0000_0000, 32'h0000_0000, 32'h8000_0000),
            make_item(32'h8000_0000, 32'h8000_0000, 32'hFF7F_FFFF),
            make_item(32'h5F00_0000, 32'h0000_0000, 32'h0000_0000),
            make_item(32'h2000_0000, 32'h0080_0000, 32'hBF00_0000)
        };
        bf_cases = '{
            make_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000),
            make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
            make_item(32'hFFFF_3F80, 32'hABCD_3C00, 32'h3F80_8000),
            make_item(32'h0000_3F80, 32'h0000_7F80, 32'h3F80_8000),
            make_item(32'h0000_BF80, 32'h0000_7FC1, 32'h0000_7FFF),
            make_item(32'h0000_7F7F, 32'h0000_7F7F, 32'hBF80_8000),
            make_item(32'h0000_0001, 32'h0000_0080, 32'h7F80_8000)
        };
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = asmu_pkg::REG_STORAGE_FORMAT;
        cfg_data = '0;
        send_idle = 7;
        recv_idle = 46;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: a zero step leaves the parameter as it was.
        send_random(50, 1'b0);

        // Binary32 storage with a typical step, directed cases first.
        set_all(32'd0, asmu_pkg::FP_ONE, 32'h3A83_126F, 32'h1E3C_E508);
        foreach (plain_cases[i])
            send_item(plain_cases[i]);
        send_random(230, 1'b0);

        // bf16 storage.
        set_all(32'd1, asmu_pkg::FP_HALF, 32'h3C23_D70A, 32'd0);
        send_idle = 46;
        recv_idle = 7;
        foreach (bf_cases[i])
            send_item(bf_cases[i]);
        send_random(230, 1'b1);

        // Extreme settings.
        set_all(32'd0, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h7F80_0000);
        send_random(100, 1'b0);
        set_all(32'hFFFF_FFFF, 32'd0, 32'h0000_0001, 32'h0000_0001);
        send_idle = 0;
        recv_idle = 0;
        send_random(100, 1'b1);
        set_all(32'd0, 32'h4000_0000, 32'h3C23_D70A, 32'h8000_0000);
        send_random(250, 1'b0);

        wait_drained();
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/asmu_pkg.sv
hw/rtl/asmu_delay.sv
hw/rtl/asmu_fma.sv
hw/rtl/adam_second_moment_update.sv
tb/testbench.sv
